### hdl/sdd_pkg.sv
// Package for the start/end delimiter deframer.
// Sizes, configuration register codes, control structs and length helper.
// No dependencies.
package sdd_pkg;

	localparam int MAX_SEQ_LEN = 8;
	localparam int LEN_WIDTH   = 16;
	localparam int POS_W       = $clog2(MAX_SEQ_LEN + 1);
	localparam int IDX_W       = (MAX_SEQ_LEN > 1) ? $clog2(MAX_SEQ_LEN) : 1;
	localparam int SEQ_W       = 8 * MAX_SEQ_LEN;
	localparam int CFG_W       = 64;
	localparam int CFG_LEN_W   = 4;

	localparam logic [LEN_WIDTH-1:0] LEN_MAX = {LEN_WIDTH{1'b1}};

	typedef enum logic [1:0] {
		CFG_START_LEN   = 2'd0,
		CFG_START_BYTES = 2'd1,
		CFG_END_LEN     = 2'd2,
		CFG_END_BYTES   = 2'd3
	} cfg_idx_t;

	// per-cycle control shared by every delay cell
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

	// zero acts as one, anything above the max acts as the max
	function automatic logic [POS_W-1:0] eff_len(input logic [CFG_LEN_W-1:0] len);
		logic [POS_W-1:0] r;
		if (len == '0) begin
			r = POS_W'(1);
		end else if (32'(len) > MAX_SEQ_LEN) begin
			r = POS_W'(MAX_SEQ_LEN);
		end else begin
			r = POS_W'(len);
		end
		return r;
	endfunction

endpackage

### hdl/sdd_cell.sv
// One stage of the payload delay line: a byte and its filled flag.
// Depends on sdd_pkg.
module sdd_cell
	import sdd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic [7:0] byte_in,
	input  logic      fill_in,
	output logic [7:0] byte_q,
	output logic      fill_q
);

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			byte_q <= byte_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 1'b0;
		end else if (ctl.clear) begin
			fill_q <= 1'b0;
		end else if (ctl.shift) begin
			fill_q <= fill_in;
		end
	end

endmodule

### hdl/sdd_match.sv
// Delimiter match step: next match position for one byte, with restart rule.
// Depends on sdd_pkg.
module sdd_match
	import sdd_pkg::*;
(
	input  logic [POS_W-1:0] pos,
	input  logic [POS_W-1:0] len,
	input  logic [SEQ_W-1:0] seq,
	input  logic [7:0]       b,
	output logic [POS_W-1:0] pos_next
);

	logic [POS_W-1:0] p;
	logic [7:0]       exp_byte;

	always_comb begin
		p        = (pos >= len) ? '0 : pos;
		exp_byte = seq[8*p[IDX_W-1:0] +: 8];
		if (b == exp_byte) begin
			pos_next = p + POS_W'(1);
		end else if (b == seq[7:0]) begin
			pos_next = POS_W'(1);
		end else begin
			pos_next = '0;
		end
	end

endmodule

### hdl/start_end_delimiter_deframer.sv
// Top level of the start/end delimiter deframer.
// Depends on sdd_pkg, sdd_match and sdd_cell.
//
//  channel  dir  handshake          payload
//  s_*      in   tvalid/tready      tdata[7:0] = in_byte
//  m_*      out  tvalid/tready      tdata = data_byte, payload_length; tlast; tuser = empty_res
//  cfg_*    in   cfg_we only        cfg_index, cfg_data
//
// One byte per cycle unless the output stalls: match, delay-line shift and result all
// settle in the accepting cycle; the output register takes the result at that edge.
// Input is taken whenever the output register is empty or being drained.
// Async reset clears state and sets config to defaults; delay bytes are not reset.
// A stall on m_tready holds one result and stops input until it drains.
module start_end_delimiter_deframer
	import sdd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] data_byte, [23:8] payload_length
	output logic        m_tlast,
	output logic        m_tuser,   // [0] empty_res
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [CFG_LEN_W-1:0] start_len_q, end_len_q;
	logic [SEQ_W-1:0]     start_bytes_q, end_bytes_q;

	logic                 in_payload_q;
	logic [POS_W-1:0]     spos_q, epos_q;
	logic [LEN_WIDTH-1:0] cnt_q;

	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic [LEN_WIDTH-1:0] out_len_q;
	logic                 out_last_q, out_empty_q;

	logic [POS_W-1:0] slen, elen, spos_next, epos_next;
	logic [IDX_W-1:0] oldest_idx;
	logic             accept, full, start_hit, end_hit, emit;
	logic [LEN_WIDTH-1:0] cnt_inc;
	cell_ctl_t        ctl;

	logic [7:0] cell_byte [MAX_SEQ_LEN];
	logic       cell_fill [MAX_SEQ_LEN];
	logic [7:0] chain_byte [MAX_SEQ_LEN];
	logic       chain_fill [MAX_SEQ_LEN];

	assign slen       = eff_len(start_len_q);
	assign elen       = eff_len(end_len_q);
	assign oldest_idx = IDX_W'(elen - POS_W'(1));
	assign full       = cell_fill[oldest_idx];

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	sdd_match u_start_match (
		.pos(spos_q), .len(slen), .seq(start_bytes_q), .b(s_tdata), .pos_next(spos_next)
	);

	sdd_match u_end_match (
		.pos(epos_q), .len(elen), .seq(end_bytes_q), .b(s_tdata), .pos_next(epos_next)
	);

	assign start_hit = !in_payload_q && (spos_next >= slen);
	assign end_hit   = in_payload_q && (epos_next >= elen);
	assign emit      = in_payload_q && (end_hit || full);
	assign cnt_inc   = (cnt_q == LEN_MAX) ? LEN_MAX : cnt_q + LEN_WIDTH'(1);

	assign ctl.shift = accept && in_payload_q && !end_hit;
	assign ctl.clear = accept && (start_hit || end_hit);

	// delay line: cell 0 takes the new byte, each cell takes its neighbor's
	genvar k;
	generate
		for (k = 0; k < MAX_SEQ_LEN; k++) begin : g_cell
			if (k == 0) begin : g_head
				assign chain_byte[k] = s_tdata;
				assign chain_fill[k] = 1'b1;
			end else begin : g_link
				assign chain_byte[k] = cell_byte[k-1];
				assign chain_fill[k] = cell_fill[k-1];
			end
			sdd_cell u_cell (
				.clk(clk), .arst_n(arst_n), .ctl(ctl),
				.byte_in(chain_byte[k]), .fill_in(chain_fill[k]),
				.byte_q(cell_byte[k]), .fill_q(cell_fill[k])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_len_q   <= CFG_LEN_W'(1);
			end_len_q     <= CFG_LEN_W'(1);
			start_bytes_q <= '0;
			end_bytes_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_START_LEN:   start_len_q   <= cfg_data[CFG_LEN_W-1:0];
				CFG_START_BYTES: start_bytes_q <= cfg_data[SEQ_W-1:0];
				CFG_END_LEN:     end_len_q     <= cfg_data[CFG_LEN_W-1:0];
				CFG_END_BYTES:   end_bytes_q   <= cfg_data[SEQ_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			spos_q       <= '0;
			epos_q       <= '0;
			cnt_q        <= '0;
		end else if (accept) begin
			if (!in_payload_q) begin
				if (start_hit) begin
					in_payload_q <= 1'b1;
					spos_q       <= '0;
					epos_q       <= '0;
					cnt_q        <= '0;
				end else begin
					spos_q <= spos_next;
				end
			end else if (end_hit) begin
				in_payload_q <= 1'b0;
				spos_q       <= '0;
				epos_q       <= '0;
				cnt_q        <= '0;
			end else begin
				epos_q <= epos_next;
				if (full) begin
					cnt_q <= cnt_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= emit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_last_q <= end_hit;
			if (end_hit && !full) begin
				// end delimiter right after the start: empty packet
				out_byte_q  <= '0;
				out_empty_q <= 1'b1;
				out_len_q   <= '0;
			end else begin
				out_byte_q  <= cell_byte[oldest_idx];
				out_empty_q <= 1'b0;
				out_len_q   <= end_hit ? cnt_inc : '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_len_q, out_byte_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_empty_q;

endmodule

### verif/tb_start_end_delimiter_deframer.sv
`timescale 1ns / 100ps
// Self-checking testbench for start_end_delimiter_deframer.
// Streams raw bytes with random gaps and back-pressure and scores every output
// transaction against a local deframer model. Depends on sdd_pkg and the RTL.
module tb_start_end_delimiter_deframer;
	import sdd_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [7:0]           data;
		logic                 last;
		logic                 empty;
		logic [LEN_WIDTH-1:0] len;
	} frame_out_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata   = '0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [23:0]      m_tdata;
	logic             m_tlast;
	logic             m_tuser;
	logic             cfg_we    = 1'b0;
	logic [1:0]       cfg_index = '0;
	logic [CFG_W-1:0] cfg_data  = '0;

	start_end_delimiter_deframer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// raw input bytes waiting for the driver, and frames the model predicts
	logic [7:0] raw_bytes_q[$];
	frame_out_t frame_out_q[$];

	int err_cnt   = 0;
	int cycle_cnt = 0;
	int in_wait   = 0;
	int out_wait  = 0;

	// model copy of the registers
	logic [3:0]       start_len_r = 4'd1;
	logic [SEQ_W-1:0] start_seq_r = '0;
	logic [3:0]       end_len_r   = 4'd1;
	logic [SEQ_W-1:0] end_seq_r   = '0;

	// model copy of the deframer state
	bit                   in_pkt    = 0;
	int                   start_pos = 0;
	int                   end_pos   = 0;
	logic [7:0]           dly[MAX_SEQ_LEN];
	int                   fill      = 0;
	logic [LEN_WIDTH-1:0] pkt_len   = '0;

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		err_cnt++;
	endtask

	function automatic int clamp_len(input logic [3:0] len);
		int r;
		r = int'(len);
		if (r == 0)
			r = 1;
		else if (r > MAX_SEQ_LEN)
			r = MAX_SEQ_LEN;
		return r;
	endfunction

	// restart rule: fall back to 1 if the byte opens the delimiter again
	function automatic int match_step(input int pos, input int len,
			input logic [SEQ_W-1:0] seq, input logic [7:0] b);
		int p;
		p = (pos >= len) ? 0 : pos;
		if (b == seq[8*p +: 8])
			return p + 1;
		return (b == seq[7:0]) ? 1 : 0;
	endfunction

	task automatic deframe_byte(input logic [7:0] b);
		int         slen;
		int         elen;
		bit         full;
		logic [7:0] oldest;
		frame_out_t r;
		slen = clamp_len(start_len_r);
		elen = clamp_len(end_len_r);
		if (!in_pkt) begin
			start_pos = match_step(start_pos, slen, start_seq_r, b);
			if (start_pos >= slen) begin
				in_pkt    = 1;
				start_pos = 0;
				end_pos   = 0;
				fill      = 0;
				pkt_len   = '0;
			end
		end else begin
			end_pos = match_step(end_pos, elen, end_seq_r, b);
			full    = (fill >= elen);
			oldest  = dly[elen-1];
			if (end_pos >= elen) begin
				in_pkt    = 0;
				start_pos = 0;
				end_pos   = 0;
				fill      = 0;
				r.last    = 1'b1;
				if (full) begin
					r.data  = oldest;
					r.empty = 1'b0;
					r.len   = (pkt_len != LEN_MAX) ? pkt_len + 1'b1 : LEN_MAX;
				end else begin
					r.data  = '0;
					r.empty = 1'b1;
					r.len   = '0;
				end
				pkt_len = '0;
				frame_out_q.insert(frame_out_q.size(), r);
			end else begin
				for (int k = MAX_SEQ_LEN - 1; k > 0; k--)
					dly[k] = dly[k-1];
				dly[0] = b;
				if (fill < MAX_SEQ_LEN)
					fill++;
				if (full) begin
					if (pkt_len != LEN_MAX)
						pkt_len++;
					r = '{data: oldest, last: 1'b0, empty: 1'b0, len: '0};
					frame_out_q.insert(frame_out_q.size(), r);
				end
			end
		end
	endtask

	// input side: one item per handshake, random gap before the next one
	always @(posedge clk) begin : drive_proc
		logic       nv;
		logic [7:0] nd;
		nv = 1'b0;
		nd = s_tdata;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				deframe_byte(s_tdata);
			if (!(s_tvalid && !s_tready)) begin
				if (in_wait > 0) begin
					in_wait--;
				end else if (raw_bytes_q.size() > 0) begin
					nd      = raw_bytes_q.pop_front();
					nv      = 1'b1;
					in_wait = $urandom_range(0, 14);
				end
				s_tvalid <= nv;
				s_tdata  <= nd;
			end
		end
	end

	// output side: score each transaction, then stall at random
	always @(posedge clk) begin : mon_proc
		frame_out_t want;
		logic       rdy;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (frame_out_q.size() == 0) begin
					report_mismatch($sformatf("unexpected transaction tdata=%h tlast=%b tuser=%b",
						m_tdata, m_tlast, m_tuser));
				end else begin
					want = frame_out_q.pop_front();
					if (m_tdata[7:0] !== want.data)
						report_mismatch($sformatf("data_byte got %h want %h",
							m_tdata[7:0], want.data));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("last got %b want %b", m_tlast, want.last));
					if (m_tuser !== want.empty)
						report_mismatch($sformatf("empty_res got %b want %b",
							m_tuser, want.empty));
					if (m_tdata[23:8] !== want.len)
						report_mismatch($sformatf("payload_length got %0d want %0d",
							m_tdata[23:8], want.len));
				end
				out_wait = $urandom_range(0, 14);
			end
			if (out_wait > 0) begin
				out_wait--;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			m_tready <= rdy;
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			CFG_START_LEN:   start_len_r = val[3:0];
			CFG_START_BYTES: start_seq_r = val;
			CFG_END_LEN:     end_len_r   = val[3:0];
			CFG_END_BYTES:   end_seq_r   = val;
			default: ;
		endcase
	endtask

	task automatic load_cfg(input logic [3:0] slen, input logic [SEQ_W-1:0] sseq,
			input logic [3:0] elen, input logic [SEQ_W-1:0] eseq);
		cfg_write(CFG_START_LEN, CFG_W'(slen));
		cfg_write(CFG_START_BYTES, sseq);
		cfg_write(CFG_END_LEN, CFG_W'(elen));
		cfg_write(CFG_END_BYTES, eseq);
	endtask

	// wait until every byte is in and every frame is out, plus the pipeline
	task automatic drain(input int extra);
		@(negedge clk);
		while (raw_bytes_q.size() != 0 || s_tvalid || frame_out_q.size() != 0)
			@(negedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic push_bytes(input logic [7:0] b[]);
		foreach (b[i])
			raw_bytes_q.insert(raw_bytes_q.size(), b[i]);
	endtask

	function automatic logic [7:0] pick_byte(input logic [SEQ_W-1:0] sseq,
			input logic [SEQ_W-1:0] eseq);
		int sel;
		sel = $urandom_range(0, 7);
		if (sel == 0)
			return sseq[8*$urandom_range(0, MAX_SEQ_LEN-1) +: 8];
		if (sel == 1)
			return eseq[8*$urandom_range(0, MAX_SEQ_LEN-1) +: 8];
		return 8'($urandom);
	endfunction

	function automatic logic [3:0] rand_len();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 4'd0;
		if (r == 1)
			return 4'($urandom_range(9, 15));
		return 4'($urandom_range(1, 8));
	endfunction

	function automatic logic [SEQ_W-1:0] rand_seq();
		logic [SEQ_W-1:0] s;
		s = {$urandom, $urandom};
		// narrow alphabet makes overlapping partial matches likely
		if ($urandom_range(0, 2) == 0)
			for (int i = 0; i < MAX_SEQ_LEN; i++)
				s[8*i +: 8] = 8'($urandom_range(0, 2));
		return s;
	endfunction

	initial begin : stim_proc
		int n_items;
		int slen;
		int elen;
		int plen;
		int kind;
		for (int k = 0; k < MAX_SEQ_LEN; k++)
			dly[k] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// two-byte delimiters, restart on repeated opener, empty packet,
		// false end opener inside the payload
		load_cfg(4'd2, 64'h817E, 4'd2, 64'h00FF);
		push_bytes('{8'h7E, 8'h7E, 8'h81, 8'hFF, 8'h00});
		push_bytes('{8'h7E, 8'h81, 8'h12, 8'hFF, 8'h34, 8'hFF, 8'h00});
		drain(4);

		// zero start length acts as one, oversize end length acts as eight
		load_cfg(4'd0, 64'hC3, 4'd15, 64'h1716151413121110);
		push_bytes('{8'hC3, 8'h5A, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15,
			8'h16, 8'h17});
		drain(4);

		// start length shrunk while a partial match is pending
		load_cfg(4'd8, 64'h0807060504030201, 4'd8, 64'h1716151413121110);
		push_bytes('{8'h01, 8'h02, 8'h03});
		drain(4);
		cfg_write(CFG_START_LEN, CFG_W'(4'd2));
		// end length shrunk once the delay line is full
		push_bytes('{8'h01, 8'h02, 8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hA4, 8'hA5,
			8'hA6, 8'hA7, 8'hA8});
		drain(4);
		load_cfg(4'd2, 64'h0201, 4'd1, 64'hEE);
		push_bytes('{8'h44, 8'hEE});
		drain(4);

		// random phases: mostly framed packets with random content
		for (int ph = 0; ph < 10; ph++) begin
			load_cfg(rand_len(), rand_seq(), rand_len(), rand_seq());
			slen = clamp_len(start_len_r);
			elen = clamp_len(end_len_r);
			n_items = 0;
			while (n_items < 42) begin
				kind = $urandom_range(0, 9);
				if (kind == 0) begin
					repeat ($urandom_range(1, 4)) begin
						raw_bytes_q.insert(raw_bytes_q.size(), 8'($urandom));
						n_items++;
					end
				end else if (kind == 1) begin
					// broken opener followed by a random byte
					for (int i = 0; i < $urandom_range(0, slen - 1); i++) begin
						raw_bytes_q.insert(raw_bytes_q.size(), start_seq_r[8*i +: 8]);
						n_items++;
					end
					raw_bytes_q.insert(raw_bytes_q.size(), 8'($urandom));
					n_items++;
				end else begin
					for (int i = 0; i < slen; i++)
						raw_bytes_q.insert(raw_bytes_q.size(), start_seq_r[8*i +: 8]);
					plen = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
					for (int i = 0; i < plen; i++)
						raw_bytes_q.insert(raw_bytes_q.size(),
							pick_byte(start_seq_r, end_seq_r));
					for (int i = 0; i < elen; i++)
						raw_bytes_q.insert(raw_bytes_q.size(), end_seq_r[8*i +: 8]);
					n_items += slen + plen + elen;
				end
			end
			drain(4);
		end

		drain(20);
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
